[hw/rtl/dllc_pkg.sv]
// Shared types and constants for the doubly linked list with cursor.
// Holds opcodes, the controller command and status structs, and pool defaults.
// No dependencies.
`default_nettype none

package dllc_pkg;

	localparam int NODES_DEF = 256;
	localparam int OP_W      = 5;
	localparam int DATA_W    = 32;

	localparam logic [OP_W-1:0] OP_INSFIRST  = 5'd0;
	localparam logic [OP_W-1:0] OP_INSLAST   = 5'd1;
	localparam logic [OP_W-1:0] OP_FIRST     = 5'd2;
	localparam logic [OP_W-1:0] OP_LAST      = 5'd3;
	localparam logic [OP_W-1:0] OP_GETFIRST  = 5'd4;
	localparam logic [OP_W-1:0] OP_GETLAST   = 5'd5;
	localparam logic [OP_W-1:0] OP_DELFIRST  = 5'd6;
	localparam logic [OP_W-1:0] OP_DELLAST   = 5'd7;
	localparam logic [OP_W-1:0] OP_DELAFTER  = 5'd8;
	localparam logic [OP_W-1:0] OP_DELBEFORE = 5'd9;
	localparam logic [OP_W-1:0] OP_INSAFTER  = 5'd10;
	localparam logic [OP_W-1:0] OP_INSBEFORE = 5'd11;
	localparam logic [OP_W-1:0] OP_GETVAL    = 5'd12;
	localparam logic [OP_W-1:0] OP_SETVAL    = 5'd13;
	localparam logic [OP_W-1:0] OP_NEXT      = 5'd14;
	localparam logic [OP_W-1:0] OP_PREV      = 5'd15;
	localparam logic [OP_W-1:0] OP_ISACTIVE  = 5'd16;
	localparam logic [OP_W-1:0] OP_DISPOSE   = 5'd17;

	// One step strobe per controller state
	typedef struct packed {
		logic load;
		logic rd1;
		logic rd2;
		logic wr1;
		logic wr2;
	} cmd_t;

	typedef struct packed {
		logic short_op;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/dllc_req_if.sv]
// Request channel: opcode and value with a valid/ready transfer.
// Depends on dllc_pkg.
`default_nettype none

interface dllc_req_if;
	logic                             valid;
	logic                             ready;
	logic [dllc_pkg::OP_W-1:0]        opcode;
	logic signed [dllc_pkg::DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

[hw/rtl/dllc_rsp_if.sv]
// Response channel: read value, error and cursor activity with valid/ready.
// Depends on dllc_pkg.
`default_nettype none

interface dllc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [dllc_pkg::DATA_W-1:0] read_value;
	logic                               error;
	logic                               active;

	modport source (output valid, output read_value, output error, output active, input ready);
	modport sink   (input valid, input read_value, input error, input active, output ready);
endinterface

`default_nettype wire

[hw/rtl/doubly_linked_list_with_cursor.sv]
// Doubly linked list with cursor over a pool of NODES nodes.
// Each list op makes two dependent node-memory reads (RD1, RD2) and two writes (WR1, WR2);
// first/last/isactive and unused opcodes skip the reads. One request is taken at a time, in
// idle only; a result still waiting holds the request before its commit.
// Reset: head, tail, cursor and free list go null, fresh count zero; node memories
// are not cleared and need no clearing pass.
`default_nettype none

module doubly_linked_list_with_cursor #(
	parameter int NODES = dllc_pkg::NODES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dllc_req_if.sink   req,
	dllc_rsp_if.source rsp
);

	dllc_pkg::cmd_t cmd;
	dllc_pkg::sts_t sts;

	dllc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dllc_dpath #(.NODES(NODES)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (req.opcode),
		.value      (req.value),
		.read_value (rsp.read_value),
		.error      (rsp.error),
		.active     (rsp.active)
	);

`ifndef SYNTH
	// A commit always leaves a result waiting
	assert property (@(posedge clk) disable iff (!arst_n) cmd.wr2 |=> rsp.valid)
		else $error("commit without result");

	// One request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n) (req.valid && req.ready) |=> !req.ready)
		else $error("second transfer while busy");

	// Step strobes never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd1, cmd.rd2, cmd.wr1, cmd.wr2}))
		else $error("overlapping step strobes");
`endif

endmodule

`default_nettype wire

[hw/rtl/dllc_ctrl.sv]
// Controller: steps each request through read, read, write, write phases; short ops skip the reads.
// Depends on dllc_pkg.
`default_nettype none

module dllc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire dllc_pkg::sts_t  sts,
	output dllc_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1  = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_WR1  = 3'd3;
	localparam logic [2:0] ST_WR2  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Decode step strobes
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.rd1  = (state_q == ST_RD1);
		cmd.rd2  = (state_q == ST_RD2);
		cmd.wr1  = (state_q == ST_WR1);
		cmd.wr2  = (state_q == ST_WR2);
	end

	// Advance through the phases; hold before commit while the result slot is taken
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = sts.short_op ? ST_WR1 : ST_RD1;
			end
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_WR1;
			ST_WR1: begin
				if (out_free) state_d = ST_WR2;
			end
			ST_WR2: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr2) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dllc_dpath.sv]
// Datapath: node memories, list pointers, allocator and result registers.
// Depends on dllc_pkg; driven by dllc_ctrl step strobes.
`default_nettype none

module dllc_dpath #(
	parameter int NODES = dllc_pkg::NODES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dllc_pkg::cmd_t                     cmd,
	output dllc_pkg::sts_t                          sts,
	input  wire logic [dllc_pkg::OP_W-1:0]          opcode,
	input  wire logic signed [dllc_pkg::DATA_W-1:0] value,
	output logic signed [dllc_pkg::DATA_W-1:0]      read_value,
	output logic                                    error,
	output logic                                    active
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int PW = $clog2(NODES + 1);
	localparam int DW = dllc_pkg::DATA_W;
	localparam logic [PW-1:0] NIL = PW'(NODES);

	// Node memories
	logic [DW-1:0] val_mem [NODES];
	logic [PW-1:0] nxt_mem [NODES];
	logic [PW-1:0] prv_mem [NODES];

	logic [dllc_pkg::OP_W-1:0] op_q;
	logic [DW-1:0]             arg_q;
	logic [PW-1:0]             head_q, tail_q, cur_q, free_q, fresh_q;
	logic [PW-1:0]             n1_q, p1_q;
	logic [DW-1:0]             v1_q;
	logic                      a1v_q, a2v_q;
	logic [PW-1:0]             rnx, rpv;
	logic [DW-1:0]             rvl;
	logic [DW-1:0]             rd_q;
	logic                      err_q, act_q;

	logic [PW-1:0] a1, a2, raddr;
	logic          raddr_v;
	logic [AW-1:0] ridx;
	logic [PW-1:0] n1_live, p1_live, n2, p2;
	logic          head_v, tail_v, cur_v, free_v;
	logic          alloc_ok, ins_go, go_ok, delaft_go, delbef_go;
	logic [PW-1:0] new_n, rel;
	logic          rel_en;

	logic          val_we, nxt_we, prv_we;
	logic [PW-1:0] val_wa, nxt_wa, prv_wa;
	logic [DW-1:0] val_wd;
	logic [PW-1:0] nxt_wd, prv_wd;

	logic [PW-1:0] head_n, tail_n, cur_n, cur_c, free_n, fresh_n;
	logic [DW-1:0] rd_n;
	logic          err_n;

	// Ops that touch no node memory skip the read phases
	assign sts.short_op = (opcode == dllc_pkg::OP_FIRST) || (opcode == dllc_pkg::OP_LAST) ||
		(opcode == dllc_pkg::OP_ISACTIVE) || (opcode > dllc_pkg::OP_DISPOSE);

	assign head_v = head_q < NIL;
	assign tail_v = tail_q < NIL;
	assign cur_v  = cur_q < NIL;
	assign free_v = free_q < NIL;

	assign n1_live = a1v_q ? rnx : NIL;
	assign p1_live = a1v_q ? rpv : NIL;
	assign n2      = a2v_q ? rnx : NIL;
	assign p2      = a2v_q ? rpv : NIL;

	// First read address
	always_comb begin
		unique case (op_q) inside
			dllc_pkg::OP_INSFIRST, dllc_pkg::OP_INSLAST,
			dllc_pkg::OP_INSAFTER, dllc_pkg::OP_INSBEFORE: a1 = free_q;
			dllc_pkg::OP_GETFIRST, dllc_pkg::OP_DELFIRST: a1 = head_q;
			dllc_pkg::OP_GETLAST, dllc_pkg::OP_DELLAST:   a1 = tail_q;
			default: a1 = cur_q;
		endcase
	end

	// Second read address follows the first read's link for delete-after/before, else the cursor
	always_comb begin
		unique case (op_q) inside
			dllc_pkg::OP_DELAFTER:  a2 = n1_live;
			dllc_pkg::OP_DELBEFORE: a2 = p1_live;
			default: a2 = cur_q;
		endcase
	end

	assign raddr   = cmd.rd1 ? a1 : a2;
	assign raddr_v = raddr < NIL;
	assign ridx    = raddr_v ? raddr[AW-1:0] : '0;

	// Allocate from the free list first, then from the never-used region
	always_comb begin
		alloc_ok = 1'b1;
		new_n    = free_q;
		if (!free_v) begin
			new_n = fresh_q;
			if (fresh_q >= NIL) alloc_ok = 1'b0;
		end
	end

	assign ins_go    = (op_q == dllc_pkg::OP_INSFIRST) || (op_q == dllc_pkg::OP_INSLAST) ||
		(((op_q == dllc_pkg::OP_INSAFTER) || (op_q == dllc_pkg::OP_INSBEFORE)) && cur_v);
	assign go_ok     = ins_go && alloc_ok;
	assign delaft_go = cur_v && (cur_q != tail_q);
	assign delbef_go = cur_v && (cur_q != head_q);

	// Node released by a delete
	always_comb begin
		rel_en = 1'b0;
		rel    = NIL;
		unique case (op_q) inside
			dllc_pkg::OP_DELFIRST: begin rel_en = head_v; rel = head_q; end
			dllc_pkg::OP_DELLAST:  begin rel_en = tail_v; rel = tail_q; end
			dllc_pkg::OP_DELAFTER: begin rel_en = delaft_go; rel = n1_q; end
			dllc_pkg::OP_DELBEFORE: begin rel_en = delbef_go; rel = p1_q; end
			default: ;
		endcase
		if (rel >= NIL) rel_en = 1'b0;
	end

	// Memory writes for the two write phases
	always_comb begin
		val_we = 1'b0; val_wa = NIL; val_wd = arg_q;
		nxt_we = 1'b0; nxt_wa = NIL; nxt_wd = NIL;
		prv_we = 1'b0; prv_wa = NIL; prv_wd = NIL;
		if (cmd.wr1) begin
			unique case (op_q) inside
				dllc_pkg::OP_INSFIRST, dllc_pkg::OP_INSLAST,
				dllc_pkg::OP_INSAFTER, dllc_pkg::OP_INSBEFORE: begin
					if (go_ok) begin
						val_we = 1'b1; val_wa = new_n;
						nxt_we = 1'b1; nxt_wa = new_n;
						prv_we = 1'b1; prv_wa = new_n;
						case (op_q)
							dllc_pkg::OP_INSFIRST: begin nxt_wd = head_q; prv_wd = NIL; end
							dllc_pkg::OP_INSLAST:  begin nxt_wd = NIL; prv_wd = tail_q; end
							dllc_pkg::OP_INSAFTER: begin nxt_wd = n2; prv_wd = cur_q; end
							default:               begin nxt_wd = cur_q; prv_wd = p2; end
						endcase
					end
				end
				dllc_pkg::OP_DELFIRST: begin
					prv_we = head_v; prv_wa = n1_q; prv_wd = NIL;
				end
				dllc_pkg::OP_DELLAST: begin
					nxt_we = tail_v; nxt_wa = p1_q; nxt_wd = NIL;
				end
				dllc_pkg::OP_DELAFTER: begin
					nxt_we = delaft_go; nxt_wa = cur_q; nxt_wd = n2;
					prv_we = delaft_go && (n1_q != tail_q); prv_wa = n2; prv_wd = cur_q;
				end
				dllc_pkg::OP_DELBEFORE: begin
					prv_we = delbef_go; prv_wa = cur_q; prv_wd = p2;
					nxt_we = delbef_go && (p1_q != head_q); nxt_wa = p2; nxt_wd = cur_q;
				end
				dllc_pkg::OP_SETVAL: begin
					val_we = cur_v; val_wa = cur_q;
				end
				dllc_pkg::OP_DISPOSE: begin
					nxt_we = head_v && tail_v; nxt_wa = tail_q; nxt_wd = free_q;
				end
				default: ;
			endcase
		end else if (cmd.wr2) begin
			unique case (op_q) inside
				dllc_pkg::OP_INSFIRST: begin
					prv_we = go_ok && head_v; prv_wa = head_q; prv_wd = new_n;
				end
				dllc_pkg::OP_INSLAST: begin
					nxt_we = go_ok && tail_v; nxt_wa = tail_q; nxt_wd = new_n;
				end
				dllc_pkg::OP_INSAFTER: begin
					nxt_we = go_ok; nxt_wa = cur_q; nxt_wd = new_n;
					prv_we = go_ok && (cur_q != tail_q); prv_wa = n2; prv_wd = new_n;
				end
				dllc_pkg::OP_INSBEFORE: begin
					prv_we = go_ok; prv_wa = cur_q; prv_wd = new_n;
					nxt_we = go_ok && (cur_q != head_q); nxt_wa = p2; nxt_wd = new_n;
				end
				dllc_pkg::OP_DELFIRST, dllc_pkg::OP_DELLAST,
				dllc_pkg::OP_DELAFTER, dllc_pkg::OP_DELBEFORE: begin
					nxt_we = rel_en; nxt_wa = rel; nxt_wd = free_q;
					prv_we = rel_en; prv_wa = rel; prv_wd = NIL;
				end
				default: ;
			endcase
		end
		// Drop writes through null pointers
		if (val_wa >= NIL) val_we = 1'b0;
		if (nxt_wa >= NIL) nxt_we = 1'b0;
		if (prv_wa >= NIL) prv_we = 1'b0;
	end

	// Node memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa[AW-1:0]] <= val_wd;
		if (nxt_we) nxt_mem[nxt_wa[AW-1:0]] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa[AW-1:0]] <= prv_wd;
		if (cmd.rd1 || cmd.rd2) begin
			rvl <= val_mem[ridx];
			rnx <= nxt_mem[ridx];
			rpv <= prv_mem[ridx];
		end
	end

	// Pointer updates and result at commit
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		cur_n   = cur_q;
		free_n  = free_q;
		fresh_n = fresh_q;
		rd_n    = '0;
		err_n   = 1'b0;
		if (ins_go) begin
			if (!alloc_ok) begin
				err_n = 1'b1;
			end else if (free_v) begin
				free_n = n1_q;
			end else begin
				fresh_n = fresh_q + PW'(1);
			end
		end
		if (rel_en) free_n = rel;
		unique case (op_q) inside
			dllc_pkg::OP_INSFIRST: begin
				if (go_ok) begin
					head_n = new_n;
					if (!head_v) tail_n = new_n;
				end
			end
			dllc_pkg::OP_INSLAST: begin
				if (go_ok) begin
					tail_n = new_n;
					if (!tail_v) head_n = new_n;
				end
			end
			dllc_pkg::OP_FIRST: cur_n = head_q;
			dllc_pkg::OP_LAST:  cur_n = tail_q;
			dllc_pkg::OP_GETFIRST: begin
				if (head_v) rd_n = v1_q; else err_n = 1'b1;
			end
			dllc_pkg::OP_GETLAST: begin
				if (tail_v) rd_n = v1_q; else err_n = 1'b1;
			end
			dllc_pkg::OP_GETVAL: begin
				if (cur_v) rd_n = v1_q; else err_n = 1'b1;
			end
			dllc_pkg::OP_DELFIRST: begin
				if (head_v) begin
					if (cur_q == head_q) cur_n = NIL;
					head_n = n1_q;
					if (n1_q >= NIL) tail_n = NIL;
				end
			end
			dllc_pkg::OP_DELLAST: begin
				if (tail_v) begin
					if (cur_q == tail_q) cur_n = NIL;
					tail_n = p1_q;
					if (p1_q >= NIL) head_n = NIL;
				end
			end
			dllc_pkg::OP_DELAFTER: begin
				if (delaft_go && (n1_q == tail_q)) tail_n = cur_q;
			end
			dllc_pkg::OP_DELBEFORE: begin
				if (delbef_go && (p1_q == head_q)) head_n = cur_q;
			end
			dllc_pkg::OP_INSAFTER: begin
				if (go_ok && (cur_q == tail_q)) tail_n = new_n;
			end
			dllc_pkg::OP_INSBEFORE: begin
				if (go_ok && (cur_q == head_q)) head_n = new_n;
			end
			dllc_pkg::OP_NEXT: begin
				if (cur_v) cur_n = n1_q;
			end
			dllc_pkg::OP_PREV: begin
				if (cur_v) cur_n = p1_q;
			end
			dllc_pkg::OP_DISPOSE: begin
				if (head_v && tail_v) free_n = head_q;
				head_n = NIL;
				tail_n = NIL;
				cur_n  = NIL;
			end
			default: ;
		endcase
		cur_c = (cur_n < NIL) ? cur_n : NIL;
	end

	// Clear and capture read-valid flags, commit list pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			cur_q   <= NIL;
			free_q  <= NIL;
			fresh_q <= '0;
			a1v_q   <= 1'b0;
			a2v_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				a1v_q <= 1'b0;
				a2v_q <= 1'b0;
			end
			if (cmd.rd1) a1v_q <= raddr_v;
			if (cmd.rd2) a2v_q <= raddr_v;
			if (cmd.wr2) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				cur_q   <= cur_c;
				free_q  <= free_n;
				fresh_q <= fresh_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			arg_q <= value;
		end
		if (cmd.rd2) begin
			n1_q <= n1_live;
			p1_q <= p1_live;
			v1_q <= a1v_q ? rvl : '0;
		end
		if (cmd.wr2) begin
			rd_q  <= rd_n;
			err_q <= err_n;
			act_q <= cur_c < NIL;
		end
	end

	assign read_value = $signed(rd_q);
	assign error      = err_q;
	assign active     = act_q;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the doubly linked list with cursor: directed table, pool fill, then random traffic.
// Depends on dllc_pkg, dllc_req_if, dllc_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

	localparam int NODES = dllc_pkg::NODES_DEF;
	localparam int NIL   = NODES;
	localparam int LIMIT = 400000;
	localparam logic [dllc_pkg::OP_W-1:0] OP_SPARE = 5'd31;

	typedef struct {
		logic [dllc_pkg::OP_W-1:0] opcode;
		logic [31:0]     value;
		logic            known;
		logic [31:0]     read_value;
		logic            error;
		logic            active;
	} row_t;

	typedef struct {
		logic [31:0] read_value;
		logic        error;
		logic        active;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dllc_req_if req ();
	dllc_rsp_if rsp ();

	doubly_linked_list_with_cursor #(.NODES(NODES)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow list state
	logic [31:0] node_val [NODES];
	int          node_nxt [NODES];
	int          node_prv [NODES];
	int head, tail, cur, free_head, fresh;
	int list_len;

	answer_t pending_answers[$];
	int      mismatches = 0;
	int      cycles = 0;
	bit      stall_long = 1'b0;
	bit      stim_done = 1'b0;

	function automatic int take_node(logic [31:0] v);
		int n;
		if (free_head != NIL) begin
			n = free_head;
			free_head = node_nxt[n];
		end else if (fresh < NODES) begin
			n = fresh;
			fresh++;
		end else begin
			return NIL;
		end
		node_val[n] = v;
		node_nxt[n] = NIL;
		node_prv[n] = NIL;
		list_len++;
		return n;
	endfunction

	function automatic void give_node(int n);
		node_nxt[n] = free_head;
		node_prv[n] = NIL;
		free_head = n;
		list_len--;
	endfunction

	// Apply one request to the shadow list and return its answer
	function automatic answer_t list_apply(logic [dllc_pkg::OP_W-1:0] op, logic [31:0] v);
		answer_t a;
		int n, d;
		a.read_value = '0;
		a.error = 1'b0;
		case (op)
			dllc_pkg::OP_INSFIRST: begin
				n = take_node(v);
				if (n == NIL) a.error = 1'b1;
				else begin
					node_nxt[n] = head;
					if (head != NIL) node_prv[head] = n; else tail = n;
					head = n;
				end
			end
			dllc_pkg::OP_INSLAST: begin
				n = take_node(v);
				if (n == NIL) a.error = 1'b1;
				else begin
					node_prv[n] = tail;
					if (tail != NIL) node_nxt[tail] = n; else head = n;
					tail = n;
				end
			end
			dllc_pkg::OP_FIRST: cur = head;
			dllc_pkg::OP_LAST: cur = tail;
			dllc_pkg::OP_GETFIRST:
				if (head != NIL) a.read_value = node_val[head]; else a.error = 1'b1;
			dllc_pkg::OP_GETLAST:
				if (tail != NIL) a.read_value = node_val[tail]; else a.error = 1'b1;
			dllc_pkg::OP_DELFIRST: if (head != NIL) begin
				d = head;
				if (cur == d) cur = NIL;
				head = node_nxt[d];
				if (head != NIL) node_prv[head] = NIL; else tail = NIL;
				give_node(d);
			end
			dllc_pkg::OP_DELLAST: if (tail != NIL) begin
				d = tail;
				if (cur == d) cur = NIL;
				tail = node_prv[d];
				if (tail != NIL) node_nxt[tail] = NIL; else head = NIL;
				give_node(d);
			end
			dllc_pkg::OP_DELAFTER: if (cur != NIL && cur != tail) begin
				d = node_nxt[cur];
				node_nxt[cur] = node_nxt[d];
				if (d != tail) node_prv[node_nxt[d]] = cur; else tail = cur;
				give_node(d);
			end
			dllc_pkg::OP_DELBEFORE: if (cur != NIL && cur != head) begin
				d = node_prv[cur];
				node_prv[cur] = node_prv[d];
				if (d != head) node_nxt[node_prv[d]] = cur; else head = cur;
				give_node(d);
			end
			dllc_pkg::OP_INSAFTER: if (cur != NIL) begin
				n = take_node(v);
				if (n == NIL) a.error = 1'b1;
				else begin
					node_nxt[n] = node_nxt[cur];
					node_prv[n] = cur;
					node_nxt[cur] = n;
					if (cur != tail) node_prv[node_nxt[n]] = n; else tail = n;
				end
			end
			dllc_pkg::OP_INSBEFORE: if (cur != NIL) begin
				n = take_node(v);
				if (n == NIL) a.error = 1'b1;
				else begin
					node_prv[n] = node_prv[cur];
					node_nxt[n] = cur;
					node_prv[cur] = n;
					if (cur != head) node_nxt[node_prv[n]] = n; else head = n;
				end
			end
			dllc_pkg::OP_GETVAL:
				if (cur != NIL) a.read_value = node_val[cur]; else a.error = 1'b1;
			dllc_pkg::OP_SETVAL: if (cur != NIL) node_val[cur] = v;
			dllc_pkg::OP_NEXT: if (cur != NIL) cur = node_nxt[cur];
			dllc_pkg::OP_PREV: if (cur != NIL) cur = node_prv[cur];
			dllc_pkg::OP_DISPOSE: begin
				if (head != NIL) begin
					node_nxt[tail] = free_head;
					free_head = head;
				end
				head = NIL;
				tail = NIL;
				cur = NIL;
				list_len = 0;
			end
			default: ;
		endcase
		a.active = (cur != NIL);
		return a;
	endfunction

	// Directed table; known rows carry a hand-read answer
	row_t directed[$];

	function automatic row_t mk(logic [dllc_pkg::OP_W-1:0] op, logic [31:0] v,
			logic known = 1'b0, logic [31:0] rv = '0, logic er = 1'b0, logic ac = 1'b0);
		row_t r;
		r.opcode = op; r.value = v; r.known = known;
		r.read_value = rv; r.error = er; r.active = ac;
		return r;
	endfunction

	task automatic send(logic [dllc_pkg::OP_W-1:0] op, logic [31:0] v, row_t row,
			bit use_row);
		answer_t a;
		a = list_apply(op, v);
		if (use_row) begin
			a.read_value = row.read_value; a.error = row.error; a.active = row.active;
		end
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.value  <= v;
		do @(posedge clk); while (!req.ready);
		pending_answers.push_back(a);
		// Burst/gap shaping
		if ($urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [dllc_pkg::OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return dllc_pkg::OP_W'($urandom_range(18, 31));
		// Lean on inserts when the list is short, on deletes when it is long
		if (list_len < 40 && r < 30)
			return (r & 1) ? dllc_pkg::OP_INSLAST : dllc_pkg::OP_INSAFTER;
		if (list_len > 200 && r < 30)
			return (r & 1) ? dllc_pkg::OP_DELFIRST : dllc_pkg::OP_DELAFTER;
		if (r < 3) return dllc_pkg::OP_DISPOSE;
		return dllc_pkg::OP_W'($urandom_range(0, 16));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus
	initial begin
		row_t r;
		req.valid = 1'b0;
		req.opcode = '0;
		req.value = '0;
		head = NIL; tail = NIL; cur = NIL; free_head = NIL; fresh = 0; list_len = 0;
		directed.push_back(mk(dllc_pkg::OP_GETFIRST, 32'd0, 1'b1, 32'd0, 1'b1, 1'b0));
		directed.push_back(mk(dllc_pkg::OP_GETLAST, 32'd0, 1'b1, 32'd0, 1'b1, 1'b0));
		directed.push_back(mk(dllc_pkg::OP_GETVAL, 32'd0, 1'b1, 32'd0, 1'b1, 1'b0));
		directed.push_back(mk(dllc_pkg::OP_DELFIRST, 32'd0, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_DELLAST, 32'd0, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_DELAFTER, 32'd0, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_INSAFTER, 32'd5, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_SETVAL, 32'd5, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_DISPOSE, 32'd0, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_INSFIRST, 32'h7fff_ffff));
		directed.push_back(mk(dllc_pkg::OP_INSLAST, 32'h8000_0000));
		directed.push_back(mk(dllc_pkg::OP_GETFIRST, 32'd0, 1'b1, 32'h7fff_ffff, 1'b0, 1'b0));
		directed.push_back(mk(dllc_pkg::OP_GETLAST, 32'd0, 1'b1, 32'h8000_0000, 1'b0, 1'b0));
		directed.push_back(mk(dllc_pkg::OP_FIRST, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_INSBEFORE, 32'hffff_ffff));
		directed.push_back(mk(dllc_pkg::OP_INSAFTER, 32'h0000_0001));
		directed.push_back(mk(dllc_pkg::OP_DELBEFORE, 32'd0));
		directed.push_back(mk(dllc_pkg::OP_NEXT, 32'd0));
		directed.push_back(mk(dllc_pkg::OP_SETVAL, 32'h5555_aaaa));
		directed.push_back(mk(dllc_pkg::OP_GETVAL, 32'd0));
		directed.push_back(mk(dllc_pkg::OP_ISACTIVE, 32'd0));
		directed.push_back(mk(dllc_pkg::OP_LAST, 32'd0));
		directed.push_back(mk(dllc_pkg::OP_NEXT, 32'd0, 1'b1, 32'd0, 1'b0, 1'b0));
		directed.push_back(mk(OP_SPARE, 32'hffff_ffff, 1'b1));
		directed.push_back(mk(dllc_pkg::OP_PREV, 32'd0, 1'b1));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			r = directed[i];
			send(r.opcode, r.value, r, r.known);
		end
		// Fill the pool to the brim to hit allocation failure
		repeat (NODES + 4) send(dllc_pkg::OP_INSLAST, $urandom, directed[0], 1'b0);
		send(dllc_pkg::OP_FIRST, 32'd0, directed[0], 1'b0);
		send(dllc_pkg::OP_INSAFTER, 32'd0, directed[0], 1'b0);
		send(dllc_pkg::OP_INSBEFORE, 32'd0, directed[0], 1'b0);
		send(dllc_pkg::OP_DISPOSE, 32'd0, directed[0], 1'b0);
		// Random traffic
		for (int i = 0; i < 1080; i++) begin
			if ($urandom_range(0, 9) == 0 && list_len > 0) begin
				send(dllc_pkg::OP_FIRST, 32'd0, directed[0], 1'b0);
				repeat ($urandom_range(0, 6)) send(dllc_pkg::OP_NEXT, 32'd0, directed[0], 1'b0);
			end
			send(pick_op(), pick_value(), directed[0], 1'b0);
		end
		req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Long receiver hold-off, counted here
	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		stall_long = 1'b1;
		repeat (200) @(posedge clk);
		stall_long = 1'b0;
	end

	// Receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) rsp.ready <= 1'b0;
		else if (stall_long) rsp.ready <= 1'b0;
		else if ((cycles / 500) % 2 == 0) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	// Check each transfer against the oldest answer
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
			end else begin
				e = pending_answers.pop_front();
				if (rsp.read_value !== e.read_value || rsp.error !== e.error ||
						rsp.active !== e.active) begin
					mismatches++;
					if (mismatches <= 10)
						$display(
							"mismatch cycle %0d: exp rv=%h err=%b act=%b got rv=%h err=%b act=%b",
							cycles, e.read_value, e.error, e.active,
							rsp.read_value, rsp.error, rsp.active);
				end
			end
		end
	end

	// Count cycles and time out
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
